// File: rtl/core/pmps_pkg.sv
// Package for the fractional PLL parameter search core: widths, constants,
// register indexes, status codes and the structs shared by the core modules.
// No dependencies.
package pmps_pkg;

  localparam int FRAC_BITS = 32;
  localparam int FREQ_W    = 32;
  localparam int REF_W     = 28;
  localparam int MULT_W    = 6;
  localparam int STEP_W    = 16;
  localparam int TRIES_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_W     = 32;

  // The ratio is held at 64.0, which needs six integer bits and the cap bit.
  localparam int RATIO_W = FRAC_BITS + 7;
  localparam int P_W     = FRAC_BITS + 8;
  localparam int DVS_W   = (RATIO_W > REF_W) ? RATIO_W : REF_W;
  localparam int DVD_W   = FREQ_W + FRAC_BITS;
  localparam int CNT_W   = $clog2(DVD_W);

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FRAC_LO   = FRAC_BITS'(ONE_Q / 20 - 3);
  localparam logic [FRAC_BITS-1:0] FRAC_HI   = FRAC_BITS'((ONE_Q * 19) / 20);
  localparam logic [FRAC_BITS-1:0] FRAC_NEAR = FRAC_BITS'(4);
  localparam logic [FRAC_BITS-1:0] FRAC_TOP  = FRAC_BITS'(ONE_Q - 4);
  localparam logic [RATIO_W-1:0]   RATIO_CAP = RATIO_W'(64'd64 << FRAC_BITS);
  localparam logic [DVS_W-1:0]     INIT_SLACK = DVS_W'(3);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] REG_REF_FREQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MULT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MULT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES = 3'd4;

  localparam logic [REF_W-1:0]   RST_REF_FREQ  = REF_W'(50000000);
  localparam logic [MULT_W-1:0]  RST_MIN_MULT  = MULT_W'(8);
  localparam logic [MULT_W-1:0]  RST_MAX_MULT  = MULT_W'(26);
  localparam logic [STEP_W-1:0]  RST_SWEEP     = STEP_W'(100);
  localparam logic [TRIES_W-1:0] RST_MAX_TRIES = TRIES_W'(1000);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // Output word: achieved_hz, mult_int, out_div, mult_frac from bit 0 up.
  localparam int RES_BITS = OUT_W + MULT_W + OUT_W + OUT_W;
  localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [REF_W-1:0]   ref_freq_hz;
    logic [MULT_W-1:0]  min_mult;
    logic [MULT_W-1:0]  max_mult;
    logic [STEP_W-1:0]  sweep_step_hz;
    logic [TRIES_W-1:0] max_tries;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    achieved_hz;
    logic [MULT_W-1:0]   mult_int;
    logic [OUT_W-1:0]    out_div;
    logic [OUT_W-1:0]    mult_frac;
  } res_t;

endpackage

// File: rtl/core/pmps_serial_div.sv
// Bit-serial restoring divider shared by all divisions of the search.
// Depends on pmps_pkg for widths and the request and response structs.
module pmps_serial_div (
  input  logic               clk,
  input  logic               rst,
  input  pmps_pkg::div_req_t req,
  output pmps_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [pmps_pkg::CNT_W-1:0]    cnt;
  logic [pmps_pkg::DVD_W-1:0]    dq;
  logic [pmps_pkg::DVS_W-1:0]    rem;
  logic [pmps_pkg::DVS_W-1:0]    dvs;
  logic [pmps_pkg::DVS_W:0]      shifted;
  logic [pmps_pkg::DVS_W:0]      diff;
  logic                          ge;

  // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
  always_comb begin
    shifted = {rem, dq[pmps_pkg::DVD_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pmps_pkg::CNT_W'(pmps_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[pmps_pkg::DVS_W-1:0] : shifted[pmps_pkg::DVS_W-1:0];
      dq  <= {dq[pmps_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dq;
  assign rsp.rem  = rem;

endmodule

// File: rtl/core/pmps_search_ctrl.sv
// Search sequencer: frequency sweep, ratio, initial divider and divider scan.
// Depends on pmps_pkg; drives the shared pmps_serial_div.
module pmps_search_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  pmps_pkg::cfg_t                cfg,
  input  logic                          start,
  input  logic [pmps_pkg::FREQ_W-1:0]   target_hz,
  output logic                          idle,
  output pmps_pkg::div_req_t            div_req,
  input  pmps_pkg::div_rsp_t            div_rsp,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pmps_pkg::res_t                res
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TRY      = 4'd1;
  localparam logic [3:0] S_RATIO    = 4'd2;
  localparam logic [3:0] S_INIT_GO  = 4'd3;
  localparam logic [3:0] S_INIT     = 4'd4;
  localparam logic [3:0] S_INIT_UP  = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_SKIP_NUM = 4'd7;
  localparam logic [3:0] S_SKIP_GO  = 4'd8;
  localparam logic [3:0] S_SKIP     = 4'd9;
  localparam logic [3:0] S_NEXT     = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  localparam int F = pmps_pkg::FRAC_BITS;

  logic [3:0]                        state;
  logic [pmps_pkg::FREQ_W:0]         freq;
  logic [pmps_pkg::TRIES_W-1:0]      tries;
  logic [pmps_pkg::RATIO_W-1:0]      ratio;
  logic [pmps_pkg::RATIO_W-1:0]      ratio_m1;
  logic [pmps_pkg::P_W-1:0]          prod;
  logic [pmps_pkg::P_W-1:0]          cdiv;
  logic                              up;
  logic [F-1:0]                      gap;
  logic [pmps_pkg::P_W-1:0]          num;
  pmps_pkg::res_t                    res_q;

  logic                              attempt_ok;
  logic [pmps_pkg::REF_W-1:0]        ref_nz;
  logic [pmps_pkg::P_W-1:0]          mnum;
  logic [pmps_pkg::P_W-1:0]          lim;
  logic [F-1:0]                      frac;
  logic [pmps_pkg::P_W-F-1:0]        ipart;
  logic                              in_band;
  logic                              near_lo;
  logic                              near_hi;
  logic                              over;
  logic                              div_big;

  always_comb begin
    attempt_ok = (tries < cfg.max_tries) && !freq[pmps_pkg::FREQ_W];
    ref_nz     = (cfg.ref_freq_hz == '0) ? pmps_pkg::REF_W'(1) : cfg.ref_freq_hz;
    mnum       = pmps_pkg::P_W'({cfg.min_mult, {F{1'b0}}});
    lim        = pmps_pkg::P_W'({cfg.max_mult, {F{1'b0}}});
    frac       = prod[F-1:0];
    ipart      = prod[pmps_pkg::P_W-1:F];
    in_band    = (frac >= pmps_pkg::FRAC_LO) && (frac <= pmps_pkg::FRAC_HI);
    near_lo    = frac <= pmps_pkg::FRAC_NEAR;
    near_hi    = frac >= pmps_pkg::FRAC_TOP;
    over       = prod >= lim;
    div_big    = 64'(cdiv) > 64'hFFFF_FFFF;
  end

  // Divider requests: ratio, initial divider, and each skip over a rejected band.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {freq[pmps_pkg::FREQ_W-1:0], {F{1'b0}}};
    div_req.divisor  = pmps_pkg::DVS_W'(ref_nz);
    case (state)
      S_TRY: begin
        div_req.start = attempt_ok;
      end
      S_INIT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = pmps_pkg::DVD_W'(mnum);
        div_req.divisor  = pmps_pkg::DVS_W'(ratio);
      end
      S_SKIP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = pmps_pkg::DVD_W'(num);
        div_req.divisor  = pmps_pkg::DVS_W'(ratio);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_TRY;
          end
        end
        S_TRY: begin
          state <= attempt_ok ? S_RATIO : S_DONE;
        end
        S_RATIO: begin
          if (div_rsp.done) begin
            state <= (div_rsp.quot == '0) ? S_DONE : S_INIT_GO;
          end
        end
        S_INIT_GO: begin
          state <= S_INIT;
        end
        S_INIT: begin
          if (div_rsp.done) begin
            state <= S_INIT_UP;
          end
        end
        S_INIT_UP: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (over) begin
            state <= S_NEXT;
          end else if (in_band || near_lo || near_hi) begin
            state <= div_big ? S_NEXT : S_DONE;
          end else begin
            state <= S_SKIP_NUM;
          end
        end
        S_SKIP_NUM: begin
          state <= S_SKIP_GO;
        end
        S_SKIP_GO: begin
          state <= S_SKIP;
        end
        S_SKIP: begin
          if (div_rsp.done) begin
            state <= S_CHECK;
          end
        end
        S_NEXT: begin
          state <= S_TRY;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        freq  <= {1'b0, target_hz};
        tries <= '0;
      end
      S_TRY: begin
        res_q <= '{status: pmps_pkg::ST_NONE, default: '0};
      end
      S_RATIO: begin
        if (div_rsp.done) begin
          res_q <= '{status: pmps_pkg::ST_ZERO, mult_int: pmps_pkg::MULT_W'(1),
                     default: '0};
          if (div_rsp.quot >= pmps_pkg::DVD_W'(pmps_pkg::RATIO_CAP)) begin
            ratio <= pmps_pkg::RATIO_CAP;
          end else begin
            ratio <= div_rsp.quot[pmps_pkg::RATIO_W-1:0];
          end
        end
      end
      S_INIT_GO: begin
        ratio_m1 <= ratio - 1'b1;
      end
      S_INIT: begin
        // ratio * floor(mnum / ratio) is mnum less the remainder.
        if (div_rsp.done) begin
          prod <= mnum - pmps_pkg::P_W'(div_rsp.rem);
          cdiv <= pmps_pkg::P_W'(div_rsp.quot);
          up   <= div_rsp.rem > pmps_pkg::INIT_SLACK;
        end
      end
      S_INIT_UP: begin
        if (up) begin
          prod <= prod + pmps_pkg::P_W'(ratio);
          cdiv <= cdiv + 1'b1;
        end
      end
      S_CHECK: begin
        gap <= ((frac < pmps_pkg::FRAC_LO) ? pmps_pkg::FRAC_LO : pmps_pkg::FRAC_TOP) - frac;
        res_q.status      <= pmps_pkg::ST_OK;
        res_q.achieved_hz <= freq[pmps_pkg::FREQ_W-1:0];
        res_q.out_div     <= pmps_pkg::OUT_W'(cdiv);
        if (in_band) begin
          res_q.mult_int  <= pmps_pkg::MULT_W'(ipart);
          res_q.mult_frac <= pmps_pkg::OUT_W'(frac);
        end else if (near_lo) begin
          res_q.mult_int  <= pmps_pkg::MULT_W'(ipart);
          res_q.mult_frac <= pmps_pkg::OUT_W'(1);
        end else begin
          res_q.mult_int  <= pmps_pkg::MULT_W'(ipart + 1'b1);
          res_q.mult_frac <= pmps_pkg::OUT_W'(1);
        end
      end
      S_SKIP_NUM: begin
        num <= pmps_pkg::P_W'(gap) + pmps_pkg::P_W'(ratio_m1);
      end
      S_SKIP_GO: begin
        prod <= prod + num;
      end
      S_SKIP: begin
        // Step count n = ceil(gap / ratio); n * ratio = num - remainder.
        if (div_rsp.done) begin
          prod <= prod - pmps_pkg::P_W'(div_rsp.rem);
          cdiv <= cdiv + pmps_pkg::P_W'(div_rsp.quot);
        end
      end
      S_NEXT: begin
        freq  <= freq + (pmps_pkg::FREQ_W + 1)'(cfg.sweep_step_hz);
        tries <= tries + 1'b1;
      end
      default: begin
        freq <= freq;
      end
    endcase
  end

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_DONE;
  assign res       = res_q;

endmodule

// File: rtl/core/pll_mck_parameter_search_core.sv
// Top level of the fractional PLL parameter search core.
// Depends on pmps_pkg, pmps_serial_div and pmps_search_ctrl.
//
// Usage: a wanted output frequency in hertz arrives as one word on s_tdata. The
// core searches a multiplier M, divider C and fraction K and sends exactly one
// result word on the master stream, with the status on m_tuser.
// Registers are written through cfg_valid/cfg_ready (always ready) with the
// register number on cfg_addr; the user must write them only while no search
// runs and no result waits, as the core itself does not enforce this.
// All divisions share one bit-serial divider. An attempt divides for the ratio,
// then for the initial divider, checks the fraction and divides once more per
// skip over a rejected fraction band; a failed attempt takes a sweep step, up
// to max_tries attempts. m_tvalid is registered from the searcher's result.
// Throughput: one item at a time; s_tready is high only while the searcher is
// idle, which it is again once its result has moved into the output register.
// A stalled receiver holds the result there; a new search may start, and its
// result waits until that register is free. Reset (rst, synchronous) restores
// the register defaults, empties the output register and idles the searcher.
module pll_mck_parameter_search_core (
  input  logic                              clk,
  input  logic                              rst,
  // Slave stream, tdata fields from bit 0: target_hz[31:0].
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pmps_pkg::FREQ_W-1:0]       s_tdata,
  // Master stream, tdata fields from bit 0: achieved_hz[31:0],
  // mult_int[37:32], out_div[69:38], mult_frac[101:70], zero padding.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pmps_pkg::TDATA_W-1:0]      m_tdata,
  // Master tuser fields from bit 0: status[1:0].
  output logic [pmps_pkg::STATUS_W-1:0]     m_tuser,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmps_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [pmps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pmps_pkg::cfg_t     cfg;
  pmps_pkg::div_req_t div_req;
  pmps_pkg::div_rsp_t div_rsp;
  pmps_pkg::res_t     res;
  logic               idle;
  logic               res_valid;
  logic               res_ready;

  assign cfg_ready = 1'b1;

  // Register file; writes to unused numbers are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_freq_hz   <= pmps_pkg::RST_REF_FREQ;
      cfg.min_mult      <= pmps_pkg::RST_MIN_MULT;
      cfg.max_mult      <= pmps_pkg::RST_MAX_MULT;
      cfg.sweep_step_hz <= pmps_pkg::RST_SWEEP;
      cfg.max_tries     <= pmps_pkg::RST_MAX_TRIES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        pmps_pkg::REG_REF_FREQ: begin
          cfg.ref_freq_hz <= cfg_data[pmps_pkg::REF_W-1:0];
        end
        pmps_pkg::REG_MIN_MULT: begin
          cfg.min_mult <= cfg_data[pmps_pkg::MULT_W-1:0];
        end
        pmps_pkg::REG_MAX_MULT: begin
          cfg.max_mult <= cfg_data[pmps_pkg::MULT_W-1:0];
        end
        pmps_pkg::REG_SWEEP: begin
          cfg.sweep_step_hz <= cfg_data[pmps_pkg::STEP_W-1:0];
        end
        pmps_pkg::REG_MAX_TRIES: begin
          cfg.max_tries <= cfg_data[pmps_pkg::TRIES_W-1:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  assign s_tready = idle;

  pmps_search_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (s_tvalid && s_tready),
    .target_hz (s_tdata),
    .idle      (idle),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pmps_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register: loads when empty or when its word is taken this cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= pmps_pkg::TDATA_W'({res.mult_frac, res.out_div, res.mult_int,
                                     res.achieved_hz});
      m_tuser <= res.status;
    end
  end

endmodule

// File: rtl/core/pmps_checker.sv
// Port-level checker for the fractional PLL parameter search core, bound to
// the top level. Depends on pmps_pkg for widths and status codes.
module pmps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pmps_pkg::TDATA_W-1:0]    m_tdata,
  input logic [pmps_pkg::STATUS_W-1:0]   m_tuser
);

  localparam logic [pmps_pkg::TDATA_W-1:0] ZERO_WORD =
    pmps_pkg::TDATA_W'(1) << pmps_pkg::OUT_W;

  // A taken word closes the slave side until that search has finished.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("slave side accepted a second word during a search");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_zero_req: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pmps_pkg::ST_ZERO |-> m_tdata == ZERO_WORD)
    else $error("zero request result is not M=1 with all else zero");

  a_no_solution: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pmps_pkg::ST_NONE |-> m_tdata == '0)
    else $error("failed search returned nonzero settings");

endmodule

bind pll_mck_parameter_search_core pmps_checker u_pmps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
